@@ src/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

  // Sizes fixed by the request and result formats
  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned OpW          = 3;
  localparam int unsigned WordW        = 32;
  localparam int unsigned OccW         = 5;

  // Request opcodes
  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      opcode;
    logic signed [WordW-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WordW-1:0]  item;
    logic        [OccW-1:0]   occupancy;
    logic                     last;
  } rsp_t;

endpackage

`default_nettype wire

@@ src/double_ended_queue.sv @@
// Double-ended queue: ring store in a synchronous RAM with head index and count.
// Push (either end) and rejected requests: result in the cycle after the request.
// Pop (either end): the entry is read through the registered RAM read port, then registered as the result in S_POP.
// List: one RAM read per entry, one result per cycle after the first.
// Reset clears head and count at once; RAM contents are undefined until written.
// Results are strobed for one cycle and cannot be stalled by the receiver.
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_e;

  // head + offset, wrapped into the ring
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [IW-1:0] o);
    logic [IW:0] s;
    s = {1'b0, h} + {1'b0, o};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [IW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                valid_q, valid_d;
  rsp_t                rsp_q, rsp_d;

  logic [WordW-1:0]    mem [DEPTH];
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [IW-1:0]       mem_raddr;
  logic [WordW-1:0]    rdata_q;

  logic                accept;
  logic                full;
  logic                empty;
  logic                list_last;

  assign accept    = start && !busy;
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign list_last = (idx_q == count_q);

  // Next-state decode
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    valid_d   = 1'b0;
    rsp_d     = '{status: ST_OK, item: '0, occupancy: OccW'(count_q), last: 1'b1};
    mem_we    = 1'b0;
    mem_waddr = slot(head_q, count_q[IW-1:0]);
    mem_raddr = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.opcode)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              valid_d = 1'b1;
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (req_i.opcode == OP_PUSH_FRONT) begin
                  head_d    = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
                  mem_waddr = head_d;
                end
                rsp_d.occupancy = OccW'(count_d);
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (empty) begin
                valid_d      = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                state_d = S_POP;
                if (req_i.opcode == OP_POP_FRONT) begin
                  head_d = slot(head_q, IW'(1));
                end else begin
                  mem_raddr = slot(head_q, count_d[IW-1:0]);
                end
              end
            end
            OP_LIST: begin
              if (empty) begin
                valid_d      = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                idx_d   = CW'(1);
                state_d = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        valid_d    = 1'b1;
        rsp_d.item = rdata_q;
        state_d    = S_IDLE;
      end
      S_LIST: begin
        valid_d    = 1'b1;
        rsp_d.item = rdata_q;
        rsp_d.last = list_last;
        idx_d      = idx_q + CW'(1);
        mem_raddr  = list_last ? head_q : slot(head_q, idx_q[IW-1:0]);
        if (list_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      rsp_q   <= rsp_d;
    end
  end

  // Entry RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= req_i.value;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_FULL) |-> full)
    else $error("full status while queue not full");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_EMPTY) |-> (empty && rsp_o.item == '0 && rsp_o.last))
    else $error("bad empty result");

  a_list_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.last) |=> rsp_valid_o)
    else $error("list results not contiguous");

endmodule

`default_nettype wire
